@@ rtl/tbm_pkg.sv @@
// Shared constants, types and codes for the triangular interaction bit matrix.
// No dependencies; every other file of the block but tbm_ram imports this package.
`timescale 1ns / 1ps

package tbm_pkg;

  // Sizing
  localparam int MAX_VARS    = 64;
  localparam int LEVEL_LIMIT = 64;
  localparam int N_CAP       = (MAX_VARS < LEVEL_LIMIT) ? MAX_VARS : LEVEL_LIMIT;
  localparam int PAIR_DEPTH  = (MAX_VARS * (MAX_VARS - 1)) / 2;

  // Field widths of the transactions
  localparam int ACTION_W = 3;
  localparam int VAR_W    = 6;
  localparam int LEVEL_W  = 6;
  localparam int MASK_W   = 64;
  localparam int CNT_W    = 7;

  localparam int LEVEL_COUNT_RESET = 64;

  // Pair store packed into words
  localparam int WORD_W     = MASK_W;
  localparam int WORD_LOG   = $clog2(WORD_W);
  localparam int PAIR_WORDS = (PAIR_DEPTH + WORD_W - 1) / WORD_W;
  localparam int WORD_AW    = $clog2(PAIR_WORDS);
  localparam int VAR_AW     = $clog2(MAX_VARS);
  localparam int POS_W      = $clog2(PAIR_DEPTH + 1);

  // Triangle index arithmetic
  localparam int SPAN_W = CNT_W + 1;
  localparam int PROD_W = SPAN_W + LEVEL_W;

  // Start-up pass covers both stores
  localparam int INIT_LEN = (MAX_VARS > PAIR_WORDS) ? MAX_VARS : PAIR_WORDS;
  localparam int INIT_W   = $clog2(INIT_LEN);

  typedef enum logic [ACTION_W-1:0] {
    ACT_MAP     = 3'd0,
    ACT_SET     = 3'd1,
    ACT_TEST    = 3'd2,
    ACT_SUPPORT = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MAP_A,
    ST_MAP_B,
    ST_PAIR_IDX,
    ST_PAIR_RD,
    ST_PAIR_WR,
    ST_ROW_SCAN,
    ST_ROW_LO,
    ST_ROW_HI,
    ST_CLEAR,
    ST_RESULT
  } state_t;

endpackage

@@ rtl/tbm_ifs.sv @@
// Channel interfaces: request, response and level-count configuration.
// Depends on tbm_pkg for field widths.
`timescale 1ns / 1ps

interface tbm_req_if import tbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VAR_W-1:0]    var_a;
  logic [VAR_W-1:0]    var_b;
  logic [LEVEL_W-1:0]  level_value;
  logic [MASK_W-1:0]   support_mask;

  modport source (output valid, action, var_a, var_b, level_value, support_mask,
                  input ready);
  modport sink   (input valid, action, var_a, var_b, level_value, support_mask,
                  output ready);
endinterface

interface tbm_rsp_if import tbm_pkg::*; ();
  logic valid;
  logic ready;
  logic interacts;
  logic status;

  modport source (output valid, interacts, status, input ready);
  modport sink   (input valid, interacts, status, output ready);
endinterface

interface tbm_cfg_if import tbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] level_count;

  modport source (output valid, level_count, input ready);
  modport sink   (input valid, level_count, output ready);
endinterface

@@ rtl/tbm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`timescale 1ns / 1ps

module tbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tbm_merge.sv @@
// Shared word merge unit: shifts a bit pattern to a bit offset across two words,
// ORs the selected half into a read word and reports any overlap. Uses tbm_pkg.
`timescale 1ns / 1ps

module tbm_merge import tbm_pkg::*; (
  input  logic [WORD_W-1:0]   rdata,
  input  logic [WORD_W-1:0]   pattern,
  input  logic [WORD_LOG-1:0] offset,
  input  logic                upper,
  output logic [WORD_W-1:0]   wdata,
  output logic                hit
);

  logic [2*WORD_W-1:0] window;
  logic [WORD_W-1:0]   half;

  // pattern placed in a two-word window, then the wanted half picked
  always_comb begin
    window = {{WORD_W{1'b0}}, pattern} << offset;
    half   = upper ? window[2*WORD_W-1:WORD_W] : window[WORD_W-1:0];
    wdata  = rdata | half;
    hit    = |(rdata & half);
  end

endmodule

@@ rtl/triangular_interaction_bit_matrix.sv @@
// Top level of the triangular interaction bit matrix: sequencer, datapath,
// level map and pair word stores. Uses tbm_pkg, tbm_ifs, tbm_ram, tbm_merge.
//
//  channel  modport  payload                                        accepted when
//  req      sink     action, var_a, var_b, level_value, support_mask  valid && ready
//  rsp      source   interacts, status                               valid && ready
//  cfg      sink     level_count                                     valid && ready
//
// One transaction at a time; req.ready is high only while idle. Map writes and
// unused actions go straight to the result; set/test look up both levels, form
// the pair index, then read the pair word and set or test its bit, stopping
// early on an error pair; clear zeroes each pair word in turn; a support mask
// visits each row below n-1 and merges two words for each row with its mask bit.
// After reset a start-up pass over INIT_LEN addresses loads the identity level
// map and zeroes the pair store; req.ready stays low meanwhile, cfg is always
// taken. A finished result waits in the rsp register; the sequencer stalls only
// when a second result is ready before the first has been taken.
`timescale 1ns / 1ps

module triangular_interaction_bit_matrix import tbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tbm_req_if.sink    req,
  tbm_rsp_if.source  rsp,
  tbm_cfg_if.sink    cfg
);

  state_t state, state_next;

  logic [INIT_W-1:0]  cnt;
  logic [CNT_W-1:0]   level_count;
  logic [CNT_W-1:0]   n_eff;
  action_t            act;
  logic [VAR_W-1:0]   vb;
  logic               var_err;
  logic [LEVEL_W-1:0] la;
  logic [LEVEL_W-1:0] lo;
  logic [LEVEL_W-1:0] hi;
  logic [PROD_W-1:0]  pos;
  logic [POS_W-1:0]   row_start;
  logic [CNT_W-1:0]   row;
  logic [CNT_W-1:0]   rem;
  logic [MASK_W-1:0]  mcur;
  logic               res_hit;
  logic               res_status;
  logic               out_valid;
  logic               out_hit;
  logic               out_status;

  logic in_acc;
  logic out_free;

  // combinational helpers
  logic [LEVEL_W-1:0] lo_c;
  logic [LEVEL_W-1:0] hi_c;
  logic               pair_err_c;
  logic [SPAN_W-1:0]  span;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  pos_c;
  logic               pos_err;
  logic [CNT_W-1:0]   row_inc;
  logic               row_more;
  logic [WORD_AW-1:0] row_word;
  logic [WORD_W-1:0]  row_pat;

  // store ports
  logic               lm_we;
  logic [VAR_AW-1:0]  lm_waddr;
  logic [LEVEL_W-1:0] lm_wdata;
  logic [VAR_AW-1:0]  lm_raddr;
  logic [LEVEL_W-1:0] lm_rdata;
  logic               pm_we;
  logic [WORD_AW-1:0] pm_waddr;
  logic [WORD_W-1:0]  pm_wdata;
  logic [WORD_AW-1:0] pm_raddr;
  logic [WORD_W-1:0]  pm_rdata;

  // merge unit ports
  logic [WORD_W-1:0]   m_pattern;
  logic [WORD_LOG-1:0] m_offset;
  logic                m_upper;
  logic [WORD_W-1:0]   m_wdata;
  logic                m_hit;

  assign req.ready     = (state == ST_IDLE);
  assign in_acc        = req.valid && req.ready;
  assign out_free      = !out_valid || rsp.ready;
  assign rsp.valid     = out_valid;
  assign rsp.interacts = out_hit;
  assign rsp.status    = out_status;
  assign cfg.ready     = 1'b1;

  // effective level count
  assign n_eff = (level_count > CNT_W'(N_CAP)) ? CNT_W'(N_CAP) : level_count;

  // pair ordering and range check on the two mapped levels
  always_comb begin
    lo_c       = (la < lm_rdata) ? la : lm_rdata;
    hi_c       = (la < lm_rdata) ? lm_rdata : la;
    pair_err_c = var_err || (la == lm_rdata) || (CNT_W'(hi_c) >= n_eff);
  end

  // triangle index: ((2n - lo - 3) * lo) / 2 + hi - 1
  always_comb begin
    span  = {n_eff, 1'b0} - SPAN_W'(lo) - SPAN_W'(3);
    prod  = PROD_W'(span * lo);
    pos_c = (prod >> 1) + PROD_W'(hi) - PROD_W'(1);
  end

  assign pos_err = (pos >= PROD_W'(PAIR_DEPTH));

  // row walk for the support mask
  always_comb begin
    row_inc  = row + CNT_W'(1);
    row_more = (row_inc < n_eff);
    row_word = WORD_AW'(row_start >> WORD_LOG);
    row_pat  = (mcur >> 1) & ~({WORD_W{1'b1}} << rem);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (cnt == INIT_W'(INIT_LEN - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (action_t'(req.action))
            ACT_SET, ACT_TEST: state_next = ST_MAP_A;
            ACT_SUPPORT:       state_next = ST_ROW_SCAN;
            ACT_CLEAR:         state_next = ST_CLEAR;
            default:           state_next = ST_RESULT;
          endcase
        end
      end
      ST_MAP_A:    state_next = ST_MAP_B;
      ST_MAP_B:    state_next = pair_err_c ? ST_RESULT : ST_PAIR_IDX;
      ST_PAIR_IDX: state_next = ST_PAIR_RD;
      ST_PAIR_RD:  state_next = pos_err ? ST_RESULT : ST_PAIR_WR;
      ST_PAIR_WR:  state_next = ST_RESULT;
      ST_ROW_SCAN: begin
        if (!row_more)    state_next = ST_RESULT;
        else if (mcur[0]) state_next = ST_ROW_LO;
      end
      ST_ROW_LO:   state_next = ST_ROW_HI;
      ST_ROW_HI:   state_next = ST_ROW_SCAN;
      ST_CLEAR: begin
        if (cnt == INIT_W'(PAIR_WORDS - 1)) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // store and merge unit controls
  always_comb begin
    lm_we     = 1'b0;
    lm_waddr  = VAR_AW'(req.var_a);
    lm_wdata  = req.level_value;
    lm_raddr  = VAR_AW'(req.var_a);
    pm_we     = 1'b0;
    pm_waddr  = row_word;
    pm_wdata  = m_wdata;
    pm_raddr  = row_word;
    m_pattern = row_pat;
    m_offset  = row_start[WORD_LOG-1:0];
    m_upper   = 1'b0;
    case (state)
      ST_INIT: begin
        lm_we    = 1'b1;
        lm_waddr = VAR_AW'(cnt);
        lm_wdata = LEVEL_W'(cnt);
        pm_we    = 1'b1;
        pm_waddr = WORD_AW'(cnt);
        pm_wdata = '0;
      end
      ST_IDLE: begin
        lm_we = in_acc && (action_t'(req.action) == ACT_MAP) && (int'(req.var_a) < MAX_VARS);
      end
      ST_MAP_A: begin
        lm_raddr = VAR_AW'(vb);
      end
      ST_PAIR_RD: begin
        pm_raddr = WORD_AW'(pos >> WORD_LOG);
      end
      ST_PAIR_WR: begin
        m_pattern = WORD_W'(1);
        m_offset  = pos[WORD_LOG-1:0];
        pm_we     = (act == ACT_SET);
        pm_waddr  = WORD_AW'(pos >> WORD_LOG);
      end
      ST_ROW_LO: begin
        pm_we    = 1'b1;
        pm_raddr = row_word + WORD_AW'(1);
      end
      ST_ROW_HI: begin
        m_upper  = 1'b1;
        pm_we    = 1'b1;
        pm_waddr = row_word + WORD_AW'(1);
      end
      ST_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = WORD_AW'(cnt);
        pm_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cnt         <= '0;
      level_count <= CNT_W'(LEVEL_COUNT_RESET);
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_CLEAR) cnt <= cnt + INIT_W'(1);
      else cnt <= '0;
      if (cfg.valid) level_count <= cfg.level_count;
      if (state == ST_RESULT && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act        <= action_t'(req.action);
      vb         <= req.var_b;
      var_err    <= (int'(req.var_a) >= MAX_VARS) || (int'(req.var_b) >= MAX_VARS);
      mcur       <= req.support_mask;
      row        <= '0;
      row_start  <= '0;
      rem        <= n_eff - CNT_W'(1);
      res_hit    <= 1'b0;
      res_status <= 1'b0;
    end
    case (state)
      ST_MAP_A: la <= lm_rdata;
      ST_MAP_B: begin
        lo <= lo_c;
        hi <= hi_c;
        if (pair_err_c) res_status <= 1'b1;
      end
      ST_PAIR_IDX: pos <= pos_c;
      ST_PAIR_RD: begin
        if (pos_err) res_status <= 1'b1;
      end
      ST_PAIR_WR: begin
        if (act == ACT_TEST) res_hit <= m_hit;
      end
      ST_ROW_SCAN, ST_ROW_HI: begin
        if (state == ST_ROW_HI || (row_more && !mcur[0])) begin
          row       <= row_inc;
          rem       <= rem - CNT_W'(1);
          row_start <= row_start + POS_W'(rem);
          mcur      <= mcur >> 1;
        end
      end
      default: begin
      end
    endcase
    if (state == ST_RESULT && out_free) begin
      out_hit    <= res_hit;
      out_status <= res_status;
    end
  end

  // variable-to-level map
  tbm_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (MAX_VARS)
  ) u_level_map (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .raddr (lm_raddr),
    .rdata (lm_rdata)
  );

  // packed upper-triangle pair bits
  tbm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PAIR_WORDS)
  ) u_pair_store (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  // shared shift/merge unit for pair and row updates
  tbm_merge u_merge (
    .rdata   (pm_rdata),
    .pattern (m_pattern),
    .offset  (m_offset),
    .upper   (m_upper),
    .wdata   (m_wdata),
    .hit     (m_hit)
  );

endmodule

@@ bench/tbm_checker.sv @@
// Checker for the triangular interaction bit matrix: watches the request,
// response and level-count channels, predicts every answer and compares it.
// Depends on tbm_pkg and the channel interfaces in tbm_ifs.
`timescale 1ns / 1ps

module tbm_checker import tbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  tbm_req_if   req,
  tbm_rsp_if   rsp,
  tbm_cfg_if   cfg,
  output int   fails,
  output int   outstanding,
  output int   checked
);

  typedef struct packed {
    logic interacts;
    logic status;
  } answer_t;

  // Own copy of the block state
  logic               pair_bits [PAIR_DEPTH];
  logic [LEVEL_W-1:0] var_level [MAX_VARS];
  logic [CNT_W-1:0]   level_count;
  answer_t            answers_due [$];
  int                 err_count;
  int                 seen_count;

  function automatic int levels_in_use();
    return (int'(level_count) > N_CAP) ? N_CAP : int'(level_count);
  endfunction

  // Packed position of the (lo, hi) level pair, lo < hi
  function automatic int tri_pos(int n, int lo, int hi);
    return ((2 * n - lo - 3) * lo) / 2 + hi - 1;
  endfunction

  // Applies one request to the state copy and returns its answer
  function automatic answer_t matrix_answer(logic [ACTION_W-1:0] act,
                                            logic [VAR_W-1:0]    va,
                                            logic [VAR_W-1:0]    vb,
                                            logic [LEVEL_W-1:0]  lv,
                                            logic [MASK_W-1:0]   mask);
    answer_t ans;
    int      n;
    int      lo;
    int      hi;
    int      pos;
    ans = '0;
    n   = levels_in_use();
    case (act)
      ACT_MAP: begin
        if (int'(va) < MAX_VARS) var_level[va] = lv;
      end
      ACT_SET, ACT_TEST: begin
        if (int'(va) >= MAX_VARS || int'(vb) >= MAX_VARS) begin
          ans.status = 1'b1;
        end else begin
          lo = int'(var_level[va]);
          hi = int'(var_level[vb]);
          if (lo > hi) begin
            pos = lo;
            lo  = hi;
            hi  = pos;
          end
          if (lo == hi || hi >= n) begin
            ans.status = 1'b1;
          end else begin
            pos = tri_pos(n, lo, hi);
            if (pos >= PAIR_DEPTH) ans.status = 1'b1;
            else if (act == ACT_SET) pair_bits[pos] = 1'b1;
            else ans.interacts = pair_bits[pos];
          end
        end
      end
      ACT_SUPPORT: begin
        // every level pair inside the mask, bits at or above n ignored
        for (lo = 0; lo + 1 < n; lo++) begin
          if (mask[lo]) begin
            for (hi = lo + 1; hi < n; hi++) begin
              pos = tri_pos(n, lo, hi);
              if (mask[hi] && pos < PAIR_DEPTH) pair_bits[pos] = 1'b1;
            end
          end
        end
      end
      ACT_CLEAR: begin
        for (pos = 0; pos < PAIR_DEPTH; pos++) pair_bits[pos] = 1'b0;
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Monitor all three channels at each edge
  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    int      k;
    if (rst) begin
      for (k = 0; k < PAIR_DEPTH; k++) pair_bits[k] = 1'b0;
      for (k = 0; k < MAX_VARS; k++) var_level[k] = LEVEL_W'(k);
      level_count = CNT_W'(LEVEL_COUNT_RESET);
      answers_due.delete();
      err_count  = 0;
      seen_count = 0;
    end else begin
      // response transaction against the oldest pending answer
      if (rsp.valid && rsp.ready) begin
        got.interacts = rsp.interacts;
        got.status    = rsp.status;
        seen_count++;
        if (answers_due.size() == 0) begin
          $display("%0t: result with nothing pending, expected none got %b", $time, got);
          err_count++;
        end else begin
          want = answers_due.pop_front();
          if (got.interacts !== want.interacts) begin
            $display("%0t: interacts mismatch, expected %b got %b",
                     $time, want.interacts, got.interacts);
            err_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %b got %b",
                     $time, want.status, got.status);
            err_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) level_count = cfg.level_count;
      if (req.valid && req.ready) begin
        answers_due.push_back(matrix_answer(req.action, req.var_a, req.var_b,
                                            req.level_value, req.support_mask));
      end
    end
    fails       <= err_count;
    checked     <= seen_count;
    outstanding <= answers_due.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the triangular interaction bit matrix: clock, reset,
// request and level-count stimulus, response pacing and the verdict.
// Depends on tbm_pkg, tbm_ifs, the block itself and tbm_checker.
`timescale 1ns / 1ps

module tb;
  import tbm_pkg::*;

  localparam int LIMIT      = 2_000_000;
  localparam int HOLD_AFTER = 150;
  localparam int LONG_HOLD  = 500;
  localparam int SETTLE     = 10;
  localparam int RECENT     = 16;
  localparam int N_PLAN     = 10;
  localparam int COUNT_PLAN [N_PLAN] = '{2, 64, 13, 1, 40, 127, 3, 0, 64, 27};

  logic clk;
  logic rst;
  int   fails;
  int   outstanding;
  int   checked;
  int   cycles;

  tbm_req_if req();
  tbm_rsp_if rsp();
  tbm_cfg_if cfg();

  triangular_interaction_bit_matrix dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  tbm_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .fails       (fails),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Stimulus-side view of the level map, used to aim at valid pairs and to build swaps
  logic [LEVEL_W-1:0] map_shadow [MAX_VARS];
  logic [VAR_W-1:0]   recent_a [RECENT];
  logic [VAR_W-1:0]   recent_b [RECENT];
  int                 recent_wr;
  int                 live_levels;
  int                 action_seen [2**ACTION_W];
  int                 sent;
  int                 settings_used;
  bit                 sender_burst;
  bit                 taker_burst;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("%0t: cycle limit reached with %0d results pending", $time, outstanding);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One request transaction, preceded by a random gap
  task automatic send_req(input logic [ACTION_W-1:0] act,
                          input logic [VAR_W-1:0]    va,
                          input logic [VAR_W-1:0]    vb,
                          input logic [LEVEL_W-1:0]  lv,
                          input logic [MASK_W-1:0]   mask);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.var_a        <= va;
    req.var_b        <= vb;
    req.level_value  <= lv;
    req.support_mask <= mask;
    do @(posedge clk); while (!req.ready);
    if (act == ACT_MAP) map_shadow[va] = lv;
    action_seen[act]++;
    sent++;
  endtask

  // Level-count write, only issued while no request is in flight
  task automatic write_count(input logic [CNT_W-1:0] value);
    cfg.valid       <= 1'b1;
    cfg.level_count <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid   <= 1'b0;
    live_levels  = (int'(value) > N_CAP) ? N_CAP : int'(value);
    settings_used++;
  endtask

  // Wait until every answer is back and the block has gone quiet
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly a variable whose level is in use, sometimes any variable
  function automatic logic [VAR_W-1:0] pick_var();
    int want;
    int v;
    if (live_levels < 1 || $urandom_range(0, 4) == 0) return VAR_W'($urandom);
    want = $urandom_range(0, live_levels - 1);
    for (v = 0; v < MAX_VARS; v++) begin
      if (int'(map_shadow[v]) == want) return VAR_W'(v);
    end
    return VAR_W'($urandom);
  endfunction

  // A few levels inside the live range
  function automatic logic [MASK_W-1:0] sparse_mask();
    logic [MASK_W-1:0] m;
    int                top;
    int                bits;
    m    = '0;
    top  = (live_levels > 0) ? live_levels - 1 : 0;
    bits = $urandom_range(0, 4);
    repeat (bits) m[$urandom_range(0, top)] = 1'b1;
    return m;
  endfunction

  task automatic random_item();
    int                 r;
    int                 slot;
    logic [VAR_W-1:0]   va;
    logic [VAR_W-1:0]   vb;
    logic [LEVEL_W-1:0] lv;
    logic [LEVEL_W-1:0] old_a;
    logic [MASK_W-1:0]  mask;
    r    = $urandom_range(0, 99);
    va   = pick_var();
    vb   = pick_var();
    lv   = LEVEL_W'($urandom);
    mask = {$urandom, $urandom};
    if (r < 12) begin
      // map writes: mostly swaps, which keep the map a permutation
      if ($urandom_range(0, 4) != 0) begin
        old_a = map_shadow[va];
        send_req(ACT_MAP, va, vb, map_shadow[vb], mask);
        send_req(ACT_MAP, vb, va, old_a, mask);
      end else begin
        send_req(ACT_MAP, va, vb, lv, mask);
      end
    end else if (r < 37) begin
      send_req(ACT_SET, va, vb, lv, mask);
      recent_a[recent_wr] = va;
      recent_b[recent_wr] = vb;
      recent_wr = (recent_wr + 1) % RECENT;
    end else if (r < 81) begin
      // half the tests aim at a recently set pair
      if ($urandom_range(0, 1) == 1) begin
        slot = $urandom_range(0, RECENT - 1);
        va   = recent_a[slot];
        vb   = recent_b[slot];
        if ($urandom_range(0, 1) == 1) begin
          va = recent_b[slot];
          vb = recent_a[slot];
        end
      end
      send_req(ACT_TEST, va, vb, lv, mask);
    end else if (r < 91) begin
      if ($urandom_range(0, 2) != 0) mask = sparse_mask();
      send_req(ACT_SUPPORT, va, vb, lv, mask);
    end else if (r < 94) begin
      send_req(ACT_CLEAR, va, vb, lv, mask);
    end else begin
      send_req(ACT_CLEAR + ACTION_W'($urandom_range(1, 3)), va, vb, lv, mask);
    end
  endtask

  task automatic random_phase(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if (k % 32 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      random_item();
    end
  endtask

  // Response side: random stalls, bursts and one long hold-off
  initial begin : response_pacing
    int stall;
    int taken;
    rsp.ready <= 1'b0;
    taken       = 0;
    taker_burst = 1'b0;
    @(posedge clk);
    forever begin
      if (taken == HOLD_AFTER) stall = LONG_HOLD;
      else if (taker_burst) stall = 0;
      else stall = $urandom_range(0, 19);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      taken++;
      if (taken % 40 == 0) taker_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // Main stimulus
  initial begin : stimulus
    int a;
    int p;
    int spare;
    for (a = 0; a < MAX_VARS; a++) map_shadow[a] = LEVEL_W'(a);
    for (a = 0; a < RECENT; a++) begin
      recent_a[a] = '0;
      recent_b[a] = '0;
    end
    for (a = 0; a < 2**ACTION_W; a++) action_seen[a] = 0;
    recent_wr     = 0;
    sent          = 0;
    settings_used = 0;
    sender_burst  = 1'b0;
    live_levels   = LEVEL_COUNT_RESET;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.action       <= ACT_MAP;
    req.var_a        <= '0;
    req.var_b        <= '0;
    req.level_value  <= '0;
    req.support_mask <= '0;
    cfg.valid        <= 1'b0;
    cfg.level_count  <= CNT_W'(LEVEL_COUNT_RESET);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Full count: far corners, either order, set then seen
    write_count(CNT_W'(64));
    send_req(ACT_TEST, 6'd0, 6'd63, 6'd0, '0);
    send_req(ACT_SET, 6'd0, 6'd63, 6'd63, '1);
    send_req(ACT_TEST, 6'd63, 6'd0, 6'd0, '0);
    // same variable twice is an error pair
    send_req(ACT_SET, 6'd5, 6'd5, 6'd0, '0);
    // two variables on one level, then the swap completed
    send_req(ACT_MAP, 6'd3, 6'd0, 6'd63, '0);
    send_req(ACT_TEST, 6'd3, 6'd63, 6'd0, '0);
    send_req(ACT_TEST, 6'd3, 6'd0, 6'd0, '0);
    send_req(ACT_MAP, 6'd63, 6'd0, 6'd3, '0);
    send_req(ACT_TEST, 6'd63, 6'd5, 6'd0, '0);
    // support masks: empty, two ends, full
    send_req(ACT_SUPPORT, 6'd0, 6'd0, 6'd0, '0);
    send_req(ACT_SUPPORT, 6'd0, 6'd0, 6'd0, 64'h8000_0000_0000_0001);
    send_req(ACT_SUPPORT, 6'd63, 6'd63, 6'd63, '1);
    send_req(ACT_TEST, 6'd10, 6'd20, 6'd0, '0);
    // clear keeps the map
    send_req(ACT_CLEAR, 6'd0, 6'd0, 6'd0, '0);
    send_req(ACT_TEST, 6'd10, 6'd20, 6'd0, '0);
    send_req(ACT_TEST, 6'd3, 6'd0, 6'd0, '0);
    // unused action codes
    for (a = int'(ACT_CLEAR) + 1; a < 2**ACTION_W; a++)
      send_req(ACTION_W'(a), '1, '1, '1, '1);
    drain();

    // Smallest legal count, and old bits read under new indexing
    write_count(CNT_W'(2));
    send_req(ACT_TEST, 6'd1, 6'd2, 6'd0, '0);
    send_req(ACT_SET, 6'd0, 6'd1, 6'd0, '0);
    drain();
    write_count(CNT_W'(64));
    send_req(ACT_TEST, 6'd0, 6'd2, 6'd0, '0);
    drain();
    // counts below two: every pair is an error
    write_count(CNT_W'(1));
    send_req(ACT_TEST, 6'd0, 6'd1, 6'd0, '0);
    send_req(ACT_SUPPORT, 6'd0, 6'd0, 6'd0, '1);
    drain();

    // Random phases over a spread of counts
    for (p = 0; p < N_PLAN; p++) begin
      write_count(CNT_W'(COUNT_PLAN[p]));
      random_phase((COUNT_PLAN[p] < 2) ? 60 : 240);
      drain();
    end

    spare = 0;
    for (a = int'(ACT_CLEAR) + 1; a < 2**ACTION_W; a++) spare += action_seen[a];
    $display("Covered %0d requests under %0d level-count writes; %0d answers compared.",
             sent, settings_used, checked);
    $display("Mix: map %0d, set %0d, test %0d, support %0d, clear %0d, unused %0d.",
             action_seen[ACT_MAP], action_seen[ACT_SET], action_seen[ACT_TEST],
             action_seen[ACT_SUPPORT], action_seen[ACT_CLEAR], spare);
    if (fails == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tbm_pkg.sv
rtl/tbm_ifs.sv
rtl/tbm_ram.sv
rtl/tbm_merge.sv
rtl/triangular_interaction_bit_matrix.sv
bench/tbm_checker.sv
bench/tb.sv
